// File: rtl/mbdlp_pkg.sv
package mbdlp_pkg;

    localparam int NUM_BUTTONS_DEFAULT = 4;
    localparam int RAW_WIDTH           = 4;
    localparam int POLL_MS             = 10;
    localparam int SETTLE_MS           = 50;
    localparam int HOLD_WIDTH          = 8;
    localparam int TIMER_WIDTH         = 16;
    localparam int LONG_BUTTON         = 1;
    localparam int S_TDATA_WIDTH       = 8;
    localparam int M_TDATA_WIDTH       = 16;
    localparam int APB_ADDR_WIDTH      = 3;
    localparam int APB_DATA_WIDTH      = 32;

    typedef logic [HOLD_WIDTH-1:0]  hold_t;
    typedef logic [TIMER_WIDTH-1:0] timer_t;

    localparam hold_t  HOLD_MAX     = '1;
    localparam hold_t  SETTLE_RESET = HOLD_WIDTH'(SETTLE_MS / POLL_MS);
    localparam timer_t LONG_RESET   = TIMER_WIDTH'(100);

    typedef enum logic [0:0] {
        REG_SETTLE_POLLS     = 1'b0,
        REG_LONG_PRESS_POLLS = 1'b1
    } reg_index_t;

endpackage

// File: rtl/multi_button_debounce_long_press.sv
// A poll word accepted at a clock edge shows on m_tdata after that edge, from the output register.
// Throughput: one poll word per cycle; the output register takes a new word
// whenever it is empty or being read in the same cycle.
// Reset (aresetn low, synchronous): buttons read released with zero hold count,
// long-press countdown stopped, output empty, registers back to 5 and 100 polls.
module multi_button_debounce_long_press #(
    parameter int NUM_BUTTONS = mbdlp_pkg::NUM_BUTTONS_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [3:0] raw_levels, [7:4] zero
    input  logic [mbdlp_pkg::S_TDATA_WIDTH-1:0]   s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [3:0] press_events, [4] long_press, [8:5] debounced_levels, [15:9] zero
    output logic [mbdlp_pkg::M_TDATA_WIDTH-1:0]   m_tdata,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mbdlp_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [mbdlp_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [mbdlp_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                  pready
);
    import mbdlp_pkg::*;

    localparam int NB_EXT = (NUM_BUTTONS > RAW_WIDTH) ? NUM_BUTTONS : RAW_WIDTH;

    hold_t      settle_polls_reg;
    timer_t     long_press_polls_reg;
    reg_index_t reg_index;
    logic       cfg_write;

    logic       last_raw_reg     [NUM_BUTTONS];
    logic       last_raw_next    [NUM_BUTTONS];
    logic       stable_reg       [NUM_BUTTONS];
    logic       stable_next      [NUM_BUTTONS];
    hold_t      hold_reg         [NUM_BUTTONS];
    hold_t      hold_next        [NUM_BUTTONS];
    timer_t     long_timer_reg;
    timer_t     long_timer_next;
    logic       long_running_reg;
    logic       long_running_next;

    logic [NB_EXT-1:0]        raw_ext;
    logic [NB_EXT-1:0]        press_vec;
    logic [NB_EXT-1:0]        level_vec;
    logic                     fired;
    logic                     s_accept;

    logic                     m_tvalid_reg;
    logic [M_TDATA_WIDTH-1:0] m_tdata_reg;
    logic [M_TDATA_WIDTH-1:0] m_tdata_next;

    function automatic hold_t pwpick_settle(input logic [APB_DATA_WIDTH-1:0] d);
        return d[HOLD_WIDTH-1:0];
    endfunction

    assign pready    = 1'b1;
    assign reg_index = reg_index_t'(paddr[2]);
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb begin
        unique case (reg_index)
            REG_SETTLE_POLLS:     prdata = APB_DATA_WIDTH'(settle_polls_reg);
            REG_LONG_PRESS_POLLS: prdata = APB_DATA_WIDTH'(long_press_polls_reg);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_polls_reg     <= SETTLE_RESET;
            long_press_polls_reg <= LONG_RESET;
        end else if (cfg_write) begin
            unique case (reg_index)
                REG_SETTLE_POLLS:     settle_polls_reg     <= pwpick_settle(pwdata);
                REG_LONG_PRESS_POLLS: long_press_polls_reg <= pwdata[TIMER_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign raw_ext  = NB_EXT'(s_tdata[RAW_WIDTH-1:0]);

    // per-button debounce, then countdown tick
    always_comb begin
        logic   loaded;
        logic   lv;
        hold_t  h;
        loaded            = 1'b0;
        lv                = 1'b0;
        h                 = '0;
        press_vec         = '0;
        level_vec         = '0;
        fired             = 1'b0;
        long_timer_next   = long_timer_reg;
        long_running_next = long_running_reg;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            lv             = raw_ext[i];
            last_raw_next[i] = last_raw_reg[i];
            stable_next[i]   = stable_reg[i];
            hold_next[i]     = hold_reg[i];
            if (lv != last_raw_reg[i]) begin
                last_raw_next[i] = lv;
                hold_next[i]     = '0;
            end else begin
                h = (hold_reg[i] != HOLD_MAX) ? hold_reg[i] + 1'b1 : hold_reg[i];
                hold_next[i] = h;
                if (lv != stable_reg[i] && h >= settle_polls_reg) begin
                    stable_next[i] = lv;
                    if (!lv) begin
                        press_vec[i] = 1'b1;
                        if (i == LONG_BUTTON) begin
                            long_timer_next   = long_press_polls_reg;
                            long_running_next = 1'b1;
                            loaded            = 1'b1;
                        end
                    end else if (i == LONG_BUTTON) begin
                        long_timer_next   = '0;
                        long_running_next = 1'b0;
                    end
                end
            end
            level_vec[i] = stable_next[i];
        end
        if (long_running_next && !loaded) begin
            if (long_timer_next <= TIMER_WIDTH'(1)) begin
                long_timer_next   = '0;
                long_running_next = 1'b0;
                fired             = 1'b1;
            end else begin
                long_timer_next = long_timer_next - 1'b1;
            end
        end
        m_tdata_next = M_TDATA_WIDTH'({level_vec[RAW_WIDTH-1:0], fired,
                                       press_vec[RAW_WIDTH-1:0]});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                last_raw_reg[i] <= 1'b1;
                stable_reg[i]   <= 1'b1;
                hold_reg[i]     <= '0;
            end
            long_timer_reg   <= '0;
            long_running_reg <= 1'b0;
        end else if (s_accept) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                last_raw_reg[i] <= last_raw_next[i];
                stable_reg[i]   <= stable_next[i];
                hold_reg[i]     <= hold_next[i];
            end
            long_timer_reg   <= long_timer_next;
            long_running_reg <= long_running_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
